[design/dcpp_pkg.sv]
// Package: shared types and constants for the decimal coordinate pair parser.
package dcpp_pkg;

    localparam int DEF_FRACTION_BITS       = 16;
    localparam int DEF_INTEGER_BITS        = 20;
    localparam int DEF_MAX_FRACTION_DIGITS = 6;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_MINUS = 8'h2d;

    localparam longint unsigned DEC_POW10 [0:7] = '{
        64'd1, 64'd10, 64'd100, 64'd1000,
        64'd10000, 64'd100000, 64'd1000000, 64'd10000000
    };

    typedef enum logic [1:0] {
        CLS_DIGIT = 2'd0,
        CLS_DOT   = 2'd1,
        CLS_MINUS = 2'd2,
        CLS_OTHER = 2'd3
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [3:0]  digit;
        logic        last;
    } char_item_t;

    typedef enum logic [2:0] {
        PH_X    = 3'b001,
        PH_Y    = 3'b010,
        PH_DONE = 3'b100
    } phase_t;

endpackage

[design/dcpp_front.sv]
// Front end: classifies each incoming character and writes it into the queue.
module dcpp_front
    import dcpp_pkg::*;
(
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] char_code,
    input  logic       end_of_text,
    input  logic       q_full,
    output logic       wr_en,
    output char_item_t wr_item
);

    always_comb
    begin
        wr_item.digit = 4'(char_code - CH_ZERO);
        wr_item.last  = end_of_text;
        if (char_code inside {[CH_ZERO:CH_NINE]})
        begin
            wr_item.cls = CLS_DIGIT;
        end
        else if (char_code == CH_DOT)
        begin
            wr_item.cls = CLS_DOT;
        end
        else if (char_code == CH_MINUS)
        begin
            wr_item.cls = CLS_MINUS;
        end
        else
        begin
            wr_item.cls = CLS_OTHER;
        end
    end

    assign in_stall = q_full;
    assign wr_en    = in_valid && !q_full;

endmodule

[design/dcpp_queue.sv]
// Short FIFO of classified items between front end and back end.
module dcpp_queue
    import dcpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       wr_en,
    input  char_item_t wr_item,
    input  logic       rd_en,
    output logic       rd_valid,
    output char_item_t rd_item,
    output logic       full
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    char_item_t       mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

[design/dcpp_back.sv]
// Back end: number accumulation, x/y bookkeeping and the result register.
module dcpp_back
    import dcpp_pkg::*;
#(
    parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
    parameter int INTEGER_BITS        = DEF_INTEGER_BITS,
    parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
)
(
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             q_valid,
    input  char_item_t                                       q_item,
    output logic                                             q_pop,
    output logic                                             out_valid,
    input  logic                                             out_stall,
    output logic signed [INTEGER_BITS+FRACTION_BITS:0]       x_value,
    output logic signed [INTEGER_BITS+FRACTION_BITS:0]       y_value,
    output logic                                             x_found,
    output logic                                             y_found
);

    localparam int MAG_W = INTEGER_BITS + FRACTION_BITS;
    localparam int VAL_W = MAG_W + 1;
    localparam int WIDE_W = MAG_W + 4;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    // rounded digit * 10^-k weights, row k = fraction digit position
    logic [FRACTION_BITS-1:0] frac_tab [0:7][0:9];

    for (genvar gd = 0; gd < 10; gd++)
    begin : g_row0
        assign frac_tab[0][gd] = '0;
    end
    for (genvar gk = 1; gk < 8; gk++)
    begin : g_rows
        for (genvar gd = 0; gd < 10; gd++)
        begin : g_cols
            assign frac_tab[gk][gd] = FRACTION_BITS'(
                ((64'(gd) << FRACTION_BITS) + DEC_POW10[gk] / 2) / DEC_POW10[gk]);
        end
    end

    function automatic logic [VAL_W-1:0] to_signed(input logic [MAG_W-1:0] mag,
                                                   input logic neg);
        logic [VAL_W-1:0] v;
        v = {1'b0, mag};
        return neg ? (~v + 1'b1) : v;
    endfunction

    phase_t           phase_reg, phase_next, phase_upd;
    logic [MAG_W-1:0] acc_reg, acc_next, acc_upd;
    logic             neg_reg, neg_next, neg_upd;
    logic [2:0]       fcnt_reg, fcnt_next, fcnt_upd;
    logic             infrac_reg, infrac_next, infrac_upd;
    logic             seen_reg, seen_next, seen_upd;
    logic [VAL_W-1:0] first_reg, first_next, first_upd;
    logic             fseen_reg, fseen_next, fseen_upd;

    logic             out_valid_reg, out_valid_next;
    logic [VAL_W-1:0] x_value_reg, x_value_next;
    logic [VAL_W-1:0] y_value_reg, y_value_next;
    logic             x_found_reg, x_found_next;
    logic             y_found_reg, y_found_next;

    logic [WIDE_W-1:0] int_sum;
    logic [MAG_W:0]    frac_sum;
    logic [2:0]        fcnt_inc;
    logic [3:0]        digit_idx;
    logic [VAL_W-1:0]  cur_val;

    assign q_pop = q_valid && (!q_item.last || !out_valid_reg || !out_stall);

    assign fcnt_inc  = fcnt_reg + 1'b1;
    assign digit_idx = (q_item.digit > 4'd9) ? 4'd0 : q_item.digit;
    assign int_sum   = (WIDE_W'(acc_reg) << 3) + (WIDE_W'(acc_reg) << 1)
                     + (WIDE_W'(q_item.digit) << FRACTION_BITS);
    assign frac_sum  = (MAG_W+1)'(acc_reg) + (MAG_W+1)'(frac_tab[fcnt_inc][digit_idx]);
    assign cur_val   = to_signed(acc_reg, neg_reg);

    always_comb
    begin
        phase_upd  = phase_reg;
        acc_upd    = acc_reg;
        neg_upd    = neg_reg;
        fcnt_upd   = fcnt_reg;
        infrac_upd = infrac_reg;
        seen_upd   = seen_reg;
        first_upd  = first_reg;
        fseen_upd  = fseen_reg;
        if (phase_reg != PH_DONE)
        begin
            case (q_item.cls)
                CLS_DIGIT:
                begin
                    seen_upd = 1'b1;
                    if (!infrac_reg)
                    begin
                        acc_upd = (int_sum > WIDE_W'(MAG_MAX)) ? MAG_MAX : acc_reg;
                        if (int_sum <= WIDE_W'(MAG_MAX))
                        begin
                            acc_upd = MAG_W'(int_sum);
                        end
                    end
                    else if (fcnt_reg < 3'(MAX_FRACTION_DIGITS))
                    begin
                        acc_upd  = frac_sum[MAG_W] ? MAG_MAX : frac_sum[MAG_W-1:0];
                        fcnt_upd = fcnt_inc;
                    end
                end
                CLS_DOT:
                begin
                    infrac_upd = 1'b1;
                    fcnt_upd   = '0;
                    seen_upd   = 1'b1;
                end
                CLS_MINUS:
                begin
                    neg_upd = 1'b1;
                end
                default:
                begin
                    if (seen_reg && phase_reg == PH_X)
                    begin
                        first_upd  = cur_val;
                        fseen_upd  = 1'b1;
                        acc_upd    = '0;
                        neg_upd    = 1'b0;
                        fcnt_upd   = '0;
                        infrac_upd = 1'b0;
                        seen_upd   = 1'b0;
                        phase_upd  = PH_Y;
                    end
                    else if (seen_reg)
                    begin
                        phase_upd = PH_DONE;
                    end
                    else
                    begin
                        acc_upd    = '0;
                        neg_upd    = 1'b0;
                        fcnt_upd   = '0;
                        infrac_upd = 1'b0;
                        seen_upd   = 1'b0;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        acc_next       = acc_reg;
        neg_next       = neg_reg;
        fcnt_next      = fcnt_reg;
        infrac_next    = infrac_reg;
        seen_next      = seen_reg;
        first_next     = first_reg;
        fseen_next     = fseen_reg;
        out_valid_next = out_valid_reg && out_stall;
        x_value_next   = x_value_reg;
        y_value_next   = y_value_reg;
        x_found_next   = x_found_reg;
        y_found_next   = y_found_reg;
        if (q_pop)
        begin
            phase_next  = phase_upd;
            acc_next    = acc_upd;
            neg_next    = neg_upd;
            fcnt_next   = fcnt_upd;
            infrac_next = infrac_upd;
            seen_next   = seen_upd;
            first_next  = first_upd;
            fseen_next  = fseen_upd;
            if (q_item.last)
            begin
                out_valid_next = 1'b1;
                x_value_next   = '0;
                y_value_next   = '0;
                x_found_next   = 1'b0;
                y_found_next   = 1'b0;
                if (phase_upd == PH_X)
                begin
                    if (seen_upd)
                    begin
                        x_value_next = to_signed(acc_upd, neg_upd);
                        x_found_next = 1'b1;
                    end
                end
                else
                begin
                    if (fseen_upd)
                    begin
                        x_value_next = first_upd;
                        x_found_next = 1'b1;
                    end
                    if (seen_upd)
                    begin
                        y_value_next = to_signed(acc_upd, neg_upd);
                        y_found_next = 1'b1;
                    end
                end
                phase_next  = PH_X;
                acc_next    = '0;
                neg_next    = 1'b0;
                fcnt_next   = '0;
                infrac_next = 1'b0;
                seen_next   = 1'b0;
                first_next  = '0;
                fseen_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_X;
            acc_reg       <= '0;
            neg_reg       <= 1'b0;
            fcnt_reg      <= '0;
            infrac_reg    <= 1'b0;
            seen_reg      <= 1'b0;
            first_reg     <= '0;
            fseen_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            neg_reg       <= neg_next;
            fcnt_reg      <= fcnt_next;
            infrac_reg    <= infrac_next;
            seen_reg      <= seen_next;
            first_reg     <= first_next;
            fseen_reg     <= fseen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_value_reg <= x_value_next;
        y_value_reg <= y_value_next;
        x_found_reg <= x_found_next;
        y_found_reg <= y_found_next;
    end

    assign out_valid = out_valid_reg;
    assign x_value   = x_value_reg;
    assign y_value   = y_value_reg;
    assign x_found   = x_found_reg;
    assign y_found   = y_found_reg;

endmodule

[design/decimal_coordinate_pair_parser_unit.sv]
// Top level of the decimal coordinate pair parser.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid / in_stall | char_code, end_of_text
//  out     | out_valid/out_stall | x_value, y_value, x_found, y_found
//
// One item per cycle sustained unless a pending stalled result holds a last item;
// a result is presented after its last item is accepted (queue write when it is
// accepted, back-end step into the result register when it is popped).
// The back end's multiply-by-ten-add / table add per item sets the pace.
// The two-entry queue decouples the sides: in_stall rises only when it is full.
// Reset is asynchronous and active low; it empties the queue and clears the parse.
module decimal_coordinate_pair_parser_unit
    import dcpp_pkg::*;
#(
    parameter int FRACTION_BITS       = DEF_FRACTION_BITS,
    parameter int INTEGER_BITS        = DEF_INTEGER_BITS,
    parameter int MAX_FRACTION_DIGITS = DEF_MAX_FRACTION_DIGITS
)
(
    input  logic                                       clk,
    input  logic                                       rst_n,
    input  logic                                       in_valid,
    output logic                                       in_stall,
    input  logic [7:0]                                 char_code,
    input  logic                                       end_of_text,
    output logic                                       out_valid,
    input  logic                                       out_stall,
    output logic signed [INTEGER_BITS+FRACTION_BITS:0] x_value,
    output logic signed [INTEGER_BITS+FRACTION_BITS:0] y_value,
    output logic                                       x_found,
    output logic                                       y_found
);

    logic       q_full;
    logic       wr_en;
    char_item_t wr_item;
    logic       q_valid;
    char_item_t q_item;
    logic       q_pop;

    dcpp_front u_front (
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .end_of_text (end_of_text),
        .q_full      (q_full),
        .wr_en       (wr_en),
        .wr_item     (wr_item)
    );

    dcpp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_item  (wr_item),
        .rd_en    (q_pop),
        .rd_valid (q_valid),
        .rd_item  (q_item),
        .full     (q_full)
    );

    dcpp_back #(
        .FRACTION_BITS       (FRACTION_BITS),
        .INTEGER_BITS        (INTEGER_BITS),
        .MAX_FRACTION_DIGITS (MAX_FRACTION_DIGITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .x_value   (x_value),
        .y_value   (y_value),
        .x_found   (x_found),
        .y_found   (y_found)
    );

endmodule

[design/dcpp_checker.sv]
// Port-level checker for the parser result channel, bound to the top level.
module dcpp_checker
    import dcpp_pkg::*;
#(
    parameter int VAL_W = DEF_INTEGER_BITS + DEF_FRACTION_BITS + 1
)
(
    input logic             clk,
    input logic             rst_n,
    input logic             out_valid,
    input logic             out_stall,
    input logic [VAL_W-1:0] x_value,
    input logic [VAL_W-1:0] y_value,
    input logic             x_found,
    input logic             y_found
);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(x_value) && $stable(y_value)
            && $stable(x_found) && $stable(y_found))
        else $error("stalled result changed");

    a_x_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !x_found |-> x_value == '0)
        else $error("missing x not zero");

    a_y_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !y_found |-> y_value == '0)
        else $error("missing y not zero");

    a_y_needs_x: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && y_found |-> x_found)
        else $error("y found without x");

endmodule

bind decimal_coordinate_pair_parser_unit dcpp_checker #(
    .VAL_W (INTEGER_BITS + FRACTION_BITS + 1)
) u_dcpp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .x_value   (x_value),
    .y_value   (y_value),
    .x_found   (x_found),
    .y_found   (y_found)
);
